[rtl/cfa_pkg.sv]
package cfa_pkg;

    typedef enum logic [2:0] {
        REQ_LOAD   = 3'd0,
        REQ_SECOND = 3'd1,
        REQ_MINUTE = 3'd2,
        REQ_HOUR   = 3'd3,
        REQ_HALF   = 3'd4,
        REQ_DAY    = 3'd5,
        REQ_MONTH  = 3'd6,
        REQ_YEAR   = 3'd7
    } req_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } date_time_t;

    typedef struct packed {
        req_t              req;
        logic signed [1:0] step;
        date_time_t        load;
    } in_item_t;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;

    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] HOUR_MAX  = 6'd23;
    localparam logic [5:0] MONTH_MAX = 6'd12;
    localparam logic [5:0] HALF_DAY  = 6'd12;
    localparam logic [5:0] FULL_DAY  = 6'd24;
    localparam logic [7:0] YEAR_SPAN = 8'd100;

    // Length of a month; an invalid month counts as 31 days.
    function automatic logic [4:0] month_days(input logic [3:0] month,
                                              input logic [6:0] year);
        logic [4:0] n;
        unique case (month)
            4'd2:                   n = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                n = 5'd31;
        endcase
        return n;
    endfunction

    // Up wraps to lo past hi; down wraps to hi at or below lo and above hi.
    function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic up,
                                             input logic [5:0] lo,
                                             input logic [5:0] hi);
        logic [5:0] r;
        if (up)
        begin
            r = (v >= hi) ? lo : v + 6'd1;
        end
        else
        begin
            r = (v <= lo || v > hi) ? hi : v - 6'd1;
        end
        return r;
    endfunction

endpackage

[rtl/cfa_step.sv]
module cfa_step (
    input  cfa_pkg::in_item_t   item,
    input  cfa_pkg::date_time_t cur,
    output cfa_pkg::date_time_t nxt
);

    logic       up;
    logic [5:0] sec_w;
    logic [5:0] min_w;
    logic [5:0] hour_w;
    logic [5:0] half_sum;
    logic [4:0] day_len;
    logic [5:0] day_w;
    logic [5:0] month_w;
    logic [3:0] month_new;
    logic [4:0] month_len;
    logic [7:0] year_sum;
    logic [6:0] year_new;
    logic [4:0] year_len;

    always_comb
    begin
        up       = (item.step == 2'sd1);
        sec_w    = cfa_pkg::wrap_step(cur.second, up, 6'd0, cfa_pkg::SEC_MAX);
        min_w    = cfa_pkg::wrap_step(cur.minute, up, 6'd0, cfa_pkg::SEC_MAX);
        hour_w   = cfa_pkg::wrap_step({1'b0, cur.hour}, up, 6'd0, cfa_pkg::HOUR_MAX);
        half_sum = {1'b0, cur.hour} + cfa_pkg::HALF_DAY;
        if (half_sum >= cfa_pkg::FULL_DAY)
        begin
            half_sum = half_sum - cfa_pkg::FULL_DAY;
        end

        day_len = cfa_pkg::month_days(cur.month, cur.year);
        day_w   = cfa_pkg::wrap_step({1'b0, cur.day}, up, 6'd1, {1'b0, day_len});

        month_w   = cfa_pkg::wrap_step({2'b00, cur.month}, up, 6'd1, cfa_pkg::MONTH_MAX);
        month_new = month_w[3:0];
        month_len = cfa_pkg::month_days(month_new, cur.year);

        // The sum stays within 98..228, so one subtraction of 100 or 200 brings it
        // into range.
        year_sum = {1'b0, cur.year} + {{6{item.step[1]}}, item.step} + cfa_pkg::YEAR_SPAN;
        if (year_sum >= {cfa_pkg::YEAR_SPAN[6:0], 1'b0})
        begin
            year_sum = year_sum - {cfa_pkg::YEAR_SPAN[6:0], 1'b0};
        end
        else if (year_sum >= cfa_pkg::YEAR_SPAN)
        begin
            year_sum = year_sum - cfa_pkg::YEAR_SPAN;
        end
        year_new = year_sum[6:0];
        year_len = cfa_pkg::month_days(cur.month, year_new);

        nxt = cur;
        unique case (item.req)
            cfa_pkg::REQ_LOAD:   nxt = item.load;
            cfa_pkg::REQ_SECOND: nxt.second = sec_w;
            cfa_pkg::REQ_MINUTE: nxt.minute = min_w;
            cfa_pkg::REQ_HOUR:   nxt.hour = hour_w[4:0];
            cfa_pkg::REQ_HALF:   nxt.hour = half_sum[4:0];
            cfa_pkg::REQ_DAY:    nxt.day = day_w[4:0];
            cfa_pkg::REQ_MONTH:
            begin
                nxt.month = month_new;
                nxt.day   = (cur.day > month_len) ? month_len : cur.day;
            end
            cfa_pkg::REQ_YEAR:
            begin
                nxt.year = year_new;
                nxt.day  = (cur.day > year_len) ? year_len : cur.day;
            end
            default: nxt = cur;
        endcase
    end

endmodule

[rtl/calendar_field_adjuster.sv]
// Calendar field adjuster: keeps a date and time (year offset from 2000,
// month, day, hour, minute, second) and applies one request per input item.
// Input channel s_*: s_tuser carries the request kind, s_tdata the step and
// the six load values. Output channel m_*: one item per input item, holding
// all six fields after the request was applied.
// An accepted item is first held in the input register; the next-state logic
// then writes the date and time register, which also drives m_tdata. A new
// item is taken every cycle, limited only by the output side.
// The date and time register also serves as the output register: it is
// updated only when the output slot is free or being emptied in that cycle.
// When the receiver stalls, the result holds, one further item waits in the
// input register, and s_tready drops until m_tready returns.
// After reset the date reads year 0, month 1, day 1, 00:00:00 and both
// channels are empty.
module calendar_field_adjuster (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // step[1:0], load_year[8:2], load_month[12:9], load_day[17:13],
    // load_hour[22:18], load_minute[28:23], load_second[34:29], zero fill
    input  logic [cfa_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [cfa_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cur_year[6:0], cur_month[10:7], cur_day[15:11], cur_hour[20:16],
    // cur_minute[26:21], cur_second[32:27], zero fill
    output logic [cfa_pkg::OUT_DATA_W-1:0] m_tdata
);

    cfa_pkg::in_item_t   in_item;
    cfa_pkg::in_item_t   item_reg;
    logic                item_valid_reg;
    logic                item_valid_next;
    cfa_pkg::date_time_t state_reg;
    cfa_pkg::date_time_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;
    logic                advance;
    logic                in_take;

    always_comb
    begin
        in_item.req         = cfa_pkg::req_t'(s_tuser[2:0]);
        in_item.step        = s_tdata[1:0];
        in_item.load.year   = s_tdata[8:2];
        in_item.load.month  = s_tdata[12:9];
        in_item.load.day    = s_tdata[17:13];
        in_item.load.hour   = s_tdata[22:18];
        in_item.load.minute = s_tdata[28:23];
        in_item.load.second = s_tdata[34:29];
    end

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = item_valid_reg && out_free;
    assign s_tready = !item_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    cfa_step u_step (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '{year: 7'd0, month: 4'd1, day: 5'd1,
                                hour: 5'd0, minute: 6'd0, second: 6'd0};
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, state_reg.second, state_reg.minute, state_reg.hour,
                       state_reg.day, state_reg.month, state_reg.year};

    // An item waiting in the input register is never dropped.
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> item_valid_reg)
        else $error("input item lost while output stalled");

    // Every processed item yields a result on the output.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed item produced no result");

    // A stalled result is never overwritten by the next item.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(state_reg))
        else $error("result changed while stalled");

    // A load request stores the load values unchanged.
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.req == cfa_pkg::REQ_LOAD) |=>
            (state_reg == $past(item_reg.load)))
        else $error("load request did not store the load values");

endmodule

[tb/sv/calendar_field_adjuster_test.sv]
module calendar_field_adjuster_test;

    localparam int CLK_PERIOD   = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic signed [1:0] STEP_UP     = 2'sb01;
    localparam logic signed [1:0] STEP_ZERO   = 2'sb00;
    localparam logic signed [1:0] STEP_DOWN   = 2'sb11;
    localparam logic signed [1:0] STEP_MINUS2 = 2'sb10;

    logic                           clk;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [cfa_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [cfa_pkg::IN_USER_W-1:0]  s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [cfa_pkg::OUT_DATA_W-1:0] m_tdata;

    // Predicted date and time after every accepted item, and the results still owed.
    cfa_pkg::date_time_t predicted_date;
    cfa_pkg::date_time_t pending_dates[$];
    cfa_pkg::date_time_t seen_date;
    cfa_pkg::date_time_t want_date;

    bit idle_en = 1'b1;
    int ready_hold = 0;
    int error_count = 0;
    int results_checked = 0;
    int loads_sent = 0;
    int steps_sent = 0;
    int toggles_sent = 0;

    calendar_field_adjuster i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("TIMEOUT with %0d results outstanding", pending_dates.size());
        $display("calendar_field_adjuster verification failed");
        $finish;
    end

    function automatic cfa_pkg::date_time_t make_date(int y, int mo, int d, int h, int mi,
                                                      int s);
        cfa_pkg::date_time_t r;
        r.year   = 7'(y);
        r.month  = 4'(mo);
        r.day    = 5'(d);
        r.hour   = 5'(h);
        r.minute = 6'(mi);
        r.second = 6'(s);
        return r;
    endfunction

    function automatic int month_length(logic [3:0] month, logic [6:0] year);
        int lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int n;
        if (month < 1 || month > 12)
            return 31;
        n = lengths[month - 1];
        if (month == 2 && year[1:0] == 2'b00)
            n++;
        return n;
    endfunction

    // Up past hi returns to lo; down at lo, or from anywhere above hi, lands on hi.
    function automatic int roll_field(int v, bit up, int lo, int hi);
        if (up)
            return (v >= hi) ? lo : v + 1;
        return (v <= lo || v > hi) ? hi : v - 1;
    endfunction

    function automatic cfa_pkg::date_time_t apply_request(cfa_pkg::date_time_t cur,
                                                          cfa_pkg::req_t req,
                                                          logic signed [1:0] stp,
                                                          cfa_pkg::date_time_t ld);
        cfa_pkg::date_time_t nxt;
        bit up;
        int v;
        nxt = cur;
        up = (stp > 0);
        case (req)
            cfa_pkg::REQ_LOAD:   nxt = ld;
            cfa_pkg::REQ_SECOND:
                nxt.second = 6'(roll_field(cur.second, up, 0, int'(cfa_pkg::SEC_MAX)));
            cfa_pkg::REQ_MINUTE:
                nxt.minute = 6'(roll_field(cur.minute, up, 0, int'(cfa_pkg::SEC_MAX)));
            cfa_pkg::REQ_HOUR:
                nxt.hour = 5'(roll_field(cur.hour, up, 0, int'(cfa_pkg::HOUR_MAX)));
            cfa_pkg::REQ_HALF:
            begin
                v = int'(cur.hour) + int'(cfa_pkg::HALF_DAY);
                if (v >= int'(cfa_pkg::FULL_DAY))
                    v -= int'(cfa_pkg::FULL_DAY);
                nxt.hour = 5'(v);
            end
            cfa_pkg::REQ_DAY:
                nxt.day = 5'(roll_field(cur.day, up, 1, month_length(cur.month, cur.year)));
            cfa_pkg::REQ_MONTH:
                nxt.month = 4'(roll_field(cur.month, up, 1, int'(cfa_pkg::MONTH_MAX)));
            cfa_pkg::REQ_YEAR:
            begin
                v = (int'(cur.year) + int'(stp) + int'(cfa_pkg::YEAR_SPAN))
                    % int'(cfa_pkg::YEAR_SPAN);
                nxt.year = 7'(v);
            end
            default: ;
        endcase
        // Month and year changes pull the day back into the new month.
        if (req == cfa_pkg::REQ_MONTH || req == cfa_pkg::REQ_YEAR)
        begin
            v = month_length(nxt.month, nxt.year);
            if (nxt.day > v)
                nxt.day = 5'(v);
        end
        return nxt;
    endfunction

    // Most gaps are zero or short; now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cfa_pkg::date_time_t random_fields(bit in_range);
        cfa_pkg::date_time_t r;
        if (in_range)
        begin
            r.year   = 7'($urandom_range(0, 99));
            r.month  = 4'($urandom_range(1, 12));
            r.day    = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(28, 31))
                                                   : 5'($urandom_range(1, 31));
            r.hour   = 5'($urandom_range(0, 23));
            r.minute = 6'($urandom_range(0, 59));
            r.second = 6'($urandom_range(0, 59));
        end
        else
        begin
            r.year   = 7'($urandom_range(0, 127));
            r.month  = 4'($urandom_range(0, 15));
            r.day    = 5'($urandom_range(0, 31));
            r.hour   = 5'($urandom_range(0, 31));
            r.minute = 6'($urandom_range(0, 63));
            r.second = 6'($urandom_range(0, 63));
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, name, got, want));
    endtask

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_item(cfa_pkg::req_t req, logic signed [1:0] stp,
                             cfa_pkg::date_time_t ld);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'b0, ld.second, ld.minute, ld.hour, ld.day, ld.month, ld.year, stp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted_date = apply_request(predicted_date, req, stp, ld);
        pending_dates.push_back(predicted_date);
        if (req == cfa_pkg::REQ_LOAD)
            loads_sent++;
        else if (req == cfa_pkg::REQ_HALF)
            toggles_sent++;
        else
            steps_sent++;
    endtask

    task automatic send_step(cfa_pkg::req_t req, logic signed [1:0] stp);
        send_item(req, stp, random_fields(1'b0));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
    endtask

    // Every field stepped down from the reset date, then up from the top of its range.
    task automatic test_range_edges();
        send_step(cfa_pkg::REQ_DAY, STEP_DOWN);
        send_step(cfa_pkg::REQ_SECOND, STEP_ZERO);
        send_step(cfa_pkg::REQ_MINUTE, STEP_DOWN);
        send_step(cfa_pkg::REQ_HOUR, STEP_MINUS2);
        send_step(cfa_pkg::REQ_MONTH, STEP_DOWN);
        send_step(cfa_pkg::REQ_YEAR, STEP_DOWN);
        send_item(cfa_pkg::REQ_LOAD, STEP_UP, make_date(99, 12, 31, 23, 59, 59));
        send_step(cfa_pkg::REQ_SECOND, STEP_UP);
        send_step(cfa_pkg::REQ_MINUTE, STEP_UP);
        send_step(cfa_pkg::REQ_HOUR, STEP_UP);
        send_step(cfa_pkg::REQ_DAY, STEP_UP);
        send_step(cfa_pkg::REQ_MONTH, STEP_UP);
        send_step(cfa_pkg::REQ_YEAR, STEP_UP);
        send_step(cfa_pkg::REQ_HALF, STEP_ZERO);
    endtask

    // Loads beyond the legal ranges are kept as given, then stepped back into range.
    task automatic test_out_of_range();
        send_item(cfa_pkg::REQ_LOAD, STEP_MINUS2, make_date(127, 15, 31, 31, 63, 63));
        send_step(cfa_pkg::REQ_HALF, STEP_UP);
        send_step(cfa_pkg::REQ_SECOND, STEP_ZERO);
        send_step(cfa_pkg::REQ_MINUTE, STEP_UP);
        send_step(cfa_pkg::REQ_DAY, STEP_DOWN);
        send_step(cfa_pkg::REQ_MONTH, STEP_UP);
        send_step(cfa_pkg::REQ_YEAR, STEP_UP);
        send_item(cfa_pkg::REQ_LOAD, STEP_ZERO, make_date(0, 0, 0, 0, 0, 0));
        // A day of zero survives the clamp after a month change.
        send_step(cfa_pkg::REQ_MONTH, STEP_ZERO);
        send_step(cfa_pkg::REQ_DAY, STEP_DOWN);
    endtask

    task automatic test_leap_clamp();
        send_item(cfa_pkg::REQ_LOAD, STEP_DOWN, make_date(4, 1, 31, 12, 30, 30));
        send_step(cfa_pkg::REQ_MONTH, STEP_UP);
        send_step(cfa_pkg::REQ_YEAR, STEP_MINUS2);
    endtask

    task automatic test_random_requests(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_item(cfa_pkg::REQ_LOAD, 2'($urandom), random_fields(1'b1));
            else if (r < 14)
                send_item(cfa_pkg::REQ_LOAD, 2'($urandom), random_fields(1'b0));
            else
                send_step(cfa_pkg::req_t'($urandom_range(1, 7)), 2'($urandom));
        end
    endtask

    // Let the block run empty, then push a burst at full rate with no stalls.
    task automatic test_drain_then_burst(int count);
        drain_results();
        idle_en = 1'b0;
        test_random_requests(count);
        idle_en = 1'b1;
    endtask

    initial
    begin
        ready_hold = 0;
        forever
        begin
            @(posedge clk);
            if (!idle_en)
                m_tready <= 1'b1;
            else if (ready_hold > 0)
            begin
                m_tready <= 1'b0;
                ready_hold--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                ready_hold = pick_gap();
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_date.year   = m_tdata[6:0];
            seen_date.month  = m_tdata[10:7];
            seen_date.day    = m_tdata[15:11];
            seen_date.hour   = m_tdata[20:16];
            seen_date.minute = m_tdata[26:21];
            seen_date.second = m_tdata[32:27];
            if (pending_dates.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_checked));
            end
            else
            begin
                want_date = pending_dates.pop_front();
                compare_field("year", seen_date.year, want_date.year);
                compare_field("month", seen_date.month, want_date.month);
                compare_field("day", seen_date.day, want_date.day);
                compare_field("hour", seen_date.hour, want_date.hour);
                compare_field("minute", seen_date.minute, want_date.minute);
                compare_field("second", seen_date.second, want_date.second);
            end
            results_checked++;
        end
    end

    initial
    begin
        predicted_date = make_date(0, 1, 1, 0, 0, 0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_range_edges();
        test_out_of_range();
        test_leap_clamp();
        test_random_requests(700);
        test_drain_then_burst(150);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d loads, %0d field steps and %0d twelve-hour toggles;",
                 loads_sent, steps_sent, toggles_sent);
        $display("%0d results checked across odd loads, leap clamps and a full-rate burst.",
                 results_checked);
        if (error_count == 0)
            $display("calendar_field_adjuster verification clean");
        else
            $display("calendar_field_adjuster verification failed");
        $finish;
    end

endmodule
